@@ rtl/rcf_pkg.sv @@
// Shared types and constants for the RGB color fade ramp.
package rcf_pkg;

  localparam int CH_COUNT = 3;

  localparam logic [6:0]  PCT_FULL     = 7'd100;
  localparam logic [15:0] DUR_RESET    = 16'd1000;
  localparam logic [6:0]  BRIGHT_RESET = 7'd100;
  localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;

  // Register select taken from paddr[2]
  localparam logic REG_DURATION = 1'b0;
  localparam logic REG_BRIGHT   = 1'b1;

  // Item kinds carried on s_tuser
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET     = 2'd1,
    OP_REFRESH = 2'd2
  } op_t;

  // Request into one multiply-divide lane
  typedef struct packed {
    logic       go;
    logic [7:0] a;
    logic [6:0] b;
  } mdreq_t;

  // Lane sequencer
  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_t;

  // Top level sequencer
  typedef enum logic [6:0] {
    ST_IDLE       = 7'b0000001,
    ST_PCT        = 7'b0000010,
    ST_RAMP_GO    = 7'b0000100,
    ST_RAMP_WAIT  = 7'b0001000,
    ST_SCALE_GO   = 7'b0010000,
    ST_SCALE_WAIT = 7'b0100000,
    ST_EMIT       = 7'b1000000
  } state_t;

  // Lane divider: 100 aligned to the top quotient bit
  localparam logic [14:0] MD_DIV_INIT = 15'd25600;
  localparam logic [3:0]  MD_MUL_LAST = 4'd6;
  localparam logic [3:0]  MD_DIV_LAST = 4'd8;

  // Percent divider: seven quotient bits
  localparam logic [2:0]  PCT_LAST    = 3'd6;

endpackage

@@ rtl/rcf_muldiv.sv @@
// Bit-serial lane computing a * b / 100, truncated.
module rcf_muldiv import rcf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  mdreq_t     req,
  output logic [8:0] quo,
  output logic       done
);

  md_state_t   state;
  logic [14:0] mcand;
  logic [6:0]  mplier;
  logic [14:0] acc;
  logic [14:0] dsh;
  logic [3:0]  cnt;

  // Shift-add multiply, then restoring divide by 100, one bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      case (state)
        MD_IDLE: begin
          done <= 1'b0;
          if (req.go) begin
            mcand  <= {7'b0, req.a};
            mplier <= req.b;
            acc    <= '0;
            quo    <= '0;
            cnt    <= '0;
            state  <= MD_MUL;
          end
        end
        MD_MUL: begin
          done <= 1'b0;
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= {mcand[13:0], 1'b0};
          mplier <= {1'b0, mplier[6:1]};
          cnt    <= (cnt == MD_MUL_LAST) ? 4'd0 : cnt + 4'd1;
          if (cnt == MD_MUL_LAST) begin
            dsh   <= MD_DIV_INIT;
            state <= MD_DIV;
          end
        end
        MD_DIV: begin
          if (acc >= dsh) begin
            acc <= acc - dsh;
            quo <= {quo[7:0], 1'b1};
          end else begin
            quo <= {quo[7:0], 1'b0};
          end
          dsh  <= {1'b0, dsh[14:1]};
          cnt  <= cnt + 4'd1;
          done <= (cnt == MD_DIV_LAST);
          if (cnt == MD_DIV_LAST) begin
            state <= MD_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= MD_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/rgb_color_fade_ramp_core.sv @@
// Top level of the three-channel linear RGB color fader.
//
//  port group   dir   payload                                  accepted when
//  s_*          in    tuser: opcode; tdata: red, green, blue   s_tvalid & s_tready
//  m_*          out   tdata: red, green, blue duty             m_tvalid & m_tready
//  APB          in    fade duration (0x0), brightness (0x4)    psel & penable & pwrite
//
//  One item at a time. A set item runs the ramp, a refresh the brightness scale,
//  and a tick the ramp then the scale, after the percent divide while elapsed is
//  below the duration. A tick with no ramp running or an unused opcode is dropped.
//  The three channel lanes run in parallel; each lane does the shift-add multiply
//  and then the divide by 100, once per set or refresh and twice per live tick.
//  A finished result sits in the output register while the next item is taken.
//  Reset (synchronous, high) clears the ramp state and loads the register defaults.
module rgb_color_fade_ramp_core import rcf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
  input  logic [1:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red_duty, green_duty, blue_duty
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t      state;
  logic [1:0]  op;
  logic [7:0]  tgt       [CH_COUNT];
  logic [7:0]  start_c   [CH_COUNT];
  logic [7:0]  goal_c    [CH_COUNT];
  logic [7:0]  col       [CH_COUNT];
  logic [7:0]  duty      [CH_COUNT];
  logic [6:0]  progress;
  logic [15:0] elapsed;
  logic [15:0] dur;
  logic [6:0]  bright;

  logic [22:0] rem;
  logic [22:0] dsh;
  logic [6:0]  pq;
  logic [2:0]  pcnt;

  logic [15:0] elapsed_inc;
  logic [22:0] elapsed_x100;
  logic        cfg_wr;

  mdreq_t      req       [CH_COUNT];
  logic [8:0]  lane_q    [CH_COUNT];
  logic        lane_done [CH_COUNT];
  logic [7:0]  mag       [CH_COUNT];
  logic [7:0]  ramp_val  [CH_COUNT];
  logic [7:0]  sat_val   [CH_COUNT];

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_BRIGHT) ? {25'b0, bright} : {16'b0, dur};

  always_ff @(posedge clk) begin
    if (rst) begin
      dur    <= DUR_RESET;
      bright <= BRIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BRIGHT) begin
        bright <= pwdata[6:0];
      end else begin
        dur <= pwdata[15:0];
      end
    end
  end

  // Saturating elapsed count and its percent dividend
  assign elapsed_inc  = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + 16'd1;
  assign elapsed_x100 = {7'b0, elapsed_inc} * 23'd100;

  assign s_tready = (state == ST_IDLE);

  // Channel lanes
  for (genvar i = 0; i < CH_COUNT; i++) begin : g_lane
    assign mag[i] = (goal_c[i] >= start_c[i]) ? goal_c[i] - start_c[i]
                                              : start_c[i] - goal_c[i];
    assign req[i].go = (state == ST_RAMP_GO) || (state == ST_SCALE_GO);
    assign req[i].a  = (state == ST_RAMP_GO) ? mag[i] : col[i];
    assign req[i].b  = (state == ST_RAMP_GO) ? progress : bright;
    assign ramp_val[i] = (goal_c[i] >= start_c[i]) ? start_c[i] + lane_q[i][7:0]
                                                   : start_c[i] - lane_q[i][7:0];
    assign sat_val[i] = lane_q[i][8] ? 8'hFF : lane_q[i][7:0];

    rcf_muldiv u_lane (
      .clk  (clk),
      .rst  (rst),
      .req  (req[i]),
      .quo  (lane_q[i]),
      .done (lane_done[i])
    );
  end

  // Item sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      progress <= PCT_FULL;
      elapsed  <= '0;
      pcnt     <= '0;
      for (int i = 0; i < CH_COUNT; i++) begin
        start_c[i] <= '0;
        goal_c[i]  <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op     <= s_tuser;
            tgt[0] <= s_tdata[7:0];
            tgt[1] <= s_tdata[15:8];
            tgt[2] <= s_tdata[23:16];
            case (s_tuser)
              OP_TICK: begin
                // Drop ticks when no ramp is running
                if (progress < PCT_FULL) begin
                  elapsed <= elapsed_inc;
                  if (elapsed_inc >= dur) begin
                    progress <= PCT_FULL;
                    state    <= ST_RAMP_GO;
                  end else begin
                    rem   <= elapsed_x100;
                    dsh   <= {1'b0, dur, 6'b0};
                    pq    <= '0;
                    pcnt  <= '0;
                    state <= ST_PCT;
                  end
                end
              end
              OP_SET: begin
                state <= ST_RAMP_GO;
              end
              OP_REFRESH: begin
                for (int i = 0; i < CH_COUNT; i++) begin
                  col[i] <= start_c[i];
                end
                state <= ST_SCALE_GO;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_PCT: begin
          // Restoring divide of elapsed*100 by the duration
          if (rem >= dsh) begin
            rem <= rem - dsh;
            pq  <= {pq[5:0], 1'b1};
          end else begin
            pq  <= {pq[5:0], 1'b0};
          end
          dsh  <= {1'b0, dsh[22:1]};
          pcnt <= pcnt + 3'd1;
          if (pcnt == PCT_LAST) begin
            progress <= {pq[5:0], (rem >= dsh)};
            state    <= ST_RAMP_GO;
          end
        end
        ST_RAMP_GO: begin
          state <= ST_RAMP_WAIT;
        end
        ST_RAMP_WAIT: begin
          if (lane_done[0] && lane_done[1] && lane_done[2]) begin
            if (op == OP_SET) begin
              // Freeze the current color and restart the ramp
              for (int i = 0; i < CH_COUNT; i++) begin
                start_c[i] <= ramp_val[i];
                goal_c[i]  <= tgt[i];
              end
              progress <= '0;
              elapsed  <= '0;
              state    <= ST_IDLE;
            end else begin
              for (int i = 0; i < CH_COUNT; i++) begin
                col[i] <= ramp_val[i];
              end
              state <= ST_SCALE_GO;
            end
          end
        end
        ST_SCALE_GO: begin
          state <= ST_SCALE_WAIT;
        end
        ST_SCALE_WAIT: begin
          if (lane_done[0] && lane_done[1] && lane_done[2]) begin
            for (int i = 0; i < CH_COUNT; i++) begin
              duty[i] <= sat_val[i];
            end
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {duty[2], duty[1], duty[0]};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/sv/rgb_color_fade_ramp_core_tb.sv @@
// Self-checking testbench for the RGB color fade ramp core.
`timescale 1ns / 1ps

module rgb_color_fade_ramp_core_tb import rcf_pkg::*; ;

  // Opcode value outside the defined set; the block must ignore it
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int SETTLE_CYCLES   = 64;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_PHASES   = 12;
  localparam int PHASE_ITEMS     = 100;
  localparam int RAMP_TICKS_MAX  = 120;

  // Duty triple as packed on m_tdata: red in the low byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } duty_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;  // red_in, green_in, blue_in
  logic [1:0]  s_tuser  = '0;  // opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // red_duty, green_duty, blue_duty
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // Fader state as predicted from the accepted items
  logic [7:0]  fade_start [CH_COUNT];
  logic [7:0]  fade_goal  [CH_COUNT];
  logic [6:0]  fade_pct;
  logic [15:0] fade_elapsed;
  logic [15:0] fade_len;
  logic [6:0]  fade_bright;

  duty_t pending_duty [$];

  bit gaps_on = 1'b1;
  bit sink_hold_req = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int live_items = 0;
  int duties_checked = 0;
  int reg_writes = 0;

  string chan_name [CH_COUNT] = '{"red", "green", "blue"};

  rgb_color_fade_ramp_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Interpolate one channel between start and goal, truncating toward zero
  function automatic logic [7:0] ramp_point(input int ch, input int pct);
    int s;
    int v;
    s = int'(fade_start[ch]);
    v = ((int'(fade_goal[ch]) - s) * pct) / int'(PCT_FULL) + s;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Scale one channel by the brightness, saturating at full duty
  function automatic logic [7:0] dim(input logic [7:0] c);
    int d;
    d = (int'(c) * int'(fade_bright)) / int'(PCT_FULL);
    if (d > 255) d = 255;
    return d[7:0];
  endfunction

  function automatic duty_t dim_color(input logic [7:0] c [CH_COUNT]);
    duty_t d;
    d.red   = dim(c[0]);
    d.green = dim(c[1]);
    d.blue  = dim(c[2]);
    return d;
  endfunction

  // Advance the predicted fader by one accepted item and queue any duty result it yields
  task automatic fader_step(input logic [1:0] op, input logic [7:0] r, g, b,
                            output bit live);
    int pct;
    logic [7:0] shown [CH_COUNT];
    live = 1'b1;
    case (op)
      OP_TICK: begin
        if (fade_pct >= PCT_FULL) begin
          live = 1'b0;
        end else begin
          if (fade_elapsed != ELAPSED_MAX) fade_elapsed = fade_elapsed + 16'd1;
          if (fade_len == 16'd0) begin
            pct = int'(PCT_FULL);
          end else begin
            pct = (int'(fade_elapsed) * int'(PCT_FULL)) / int'(fade_len);
            if (pct > int'(PCT_FULL)) pct = int'(PCT_FULL);
          end
          fade_pct = pct[6:0];
          for (int ch = 0; ch < CH_COUNT; ch++) shown[ch] = ramp_point(ch, pct);
          pending_duty.push_back(dim_color(shown));
        end
      end
      OP_SET: begin
        // Freeze the color on show as the new start
        for (int ch = 0; ch < CH_COUNT; ch++) shown[ch] = ramp_point(ch, int'(fade_pct));
        fade_start = shown;
        fade_goal[0] = r;
        fade_goal[1] = g;
        fade_goal[2] = b;
        fade_pct = '0;
        fade_elapsed = '0;
      end
      OP_REFRESH: begin
        pending_duty.push_back(dim_color(fade_start));
      end
      default: begin
        live = 1'b0;
      end
    endcase
  endtask

  // Offer one item, after a random gap if gaps are on, and hold it until accepted
  task automatic send_item(input logic [1:0] op, input logic [7:0] r, g, b);
    int gap;
    bit live;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser  <= op;
    s_tdata  <= {b, g, r};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    fader_step(op, r, g, b, live);
    items_sent++;
    if (live) live_items++;
    @(negedge clk);
  endtask

  task automatic send_noise(input logic [1:0] op);
    send_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  // Stop offering items, wait for every queued duty, then let the block settle
  task automatic drain();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (pending_duty.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_duty.size() != 0) begin
      errors++;
      $display("%0t: expected %0d more duty items, got none", $time, pending_duty.size());
      pending_duty.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write with a setup and an access phase; the register updates at the access edge
  task automatic write_reg(input logic regsel, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {regsel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (regsel == REG_DURATION) fade_len = value[15:0];
    else fade_bright = value[6:0];
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] len, input logic [6:0] bright);
    drain();
    write_reg(REG_DURATION, {16'd0, len});
    write_reg(REG_BRIGHT, {25'd0, bright});
  endtask

  task automatic test_reset_state();
    send_noise(OP_TICK);
    send_noise(OP_REFRESH);
    send_noise(OP_SPARE);
  endtask

  task automatic test_zero_duration();
    configure(16'd0, 7'd100);
    send_item(OP_SET, 8'd255, 8'd0, 8'd128);
    send_noise(OP_TICK);
    send_noise(OP_TICK);
    send_noise(OP_REFRESH);
    send_item(OP_SET, 8'd0, 8'd255, 8'd1);
    send_noise(OP_REFRESH);
  endtask

  task automatic test_bright_extremes();
    // Full white ramp, retargeted mid-way, at over-range brightness
    configure(16'd3, 7'd127);
    send_item(OP_SET, 8'd255, 8'd255, 8'd255);
    send_noise(OP_TICK);
    send_item(OP_SET, 8'd0, 8'd0, 8'd0);
    repeat (4) send_noise(OP_TICK);
    send_noise(OP_REFRESH);
    configure(16'd65535, 7'd0);
    send_noise(OP_REFRESH);
    send_item(OP_SET, 8'd200, 8'd17, 8'd99);
    send_noise(OP_TICK);
    configure(16'd1000, 7'd50);
    send_noise(OP_REFRESH);
  endtask

  task automatic test_output_stall();
    configure(16'd5, 7'd100);
    send_item(OP_SET, 8'd10, 8'd200, 8'd30);
    sink_hold_req = 1'b1;
    repeat (4) send_noise(OP_TICK);
    repeat (8) send_noise(OP_REFRESH);
  endtask

  task automatic test_random_ramps();
    int target;
    int span;
    int ticks;
    logic [15:0] len;
    logic [6:0] bright;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0:       len = 16'd0;
        1:       len = 16'd65535;
        2:       len = 16'($urandom_range(100, 1000));
        default: len = 16'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 5))
        0:       bright = 7'd0;
        1:       bright = 7'd100;
        2:       bright = 7'd127;
        3:       bright = 7'($urandom_range(0, 127));
        default: bright = 7'($urandom_range(0, 100));
      endcase
      configure(len, bright);
      gaps_on = (phase % 3 != 2);
      target = live_items + PHASE_ITEMS;
      while (live_items < target) begin
        if ($urandom_range(0, 9) < 7) begin
          // Well-formed ramp: new target, then a run of ticks
          send_noise(OP_SET);
          span = int'(fade_len) + 3;
          if (span > RAMP_TICKS_MAX) span = RAMP_TICKS_MAX;
          ticks = $urandom_range(1, span);
          for (int k = 0; k < ticks; k++) begin
            send_noise(OP_TICK);
            if ($urandom_range(0, 9) == 0) send_noise(OP_REFRESH);
          end
        end else begin
          send_noise(2'($urandom_range(0, 3)));
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // Receiver: random stall per item while gaps are on, or one long hold-off on request
  initial begin : duty_sink
    int stall;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (sink_hold_req) begin
        stall = HOLD_OFF_CYCLES;
        sink_hold_req = 1'b0;
      end else begin
        stall = gaps_on ? $urandom_range(0, 4) : 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Compare each accepted duty item with the oldest prediction
  always @(posedge clk) begin : duty_check
    duty_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_duty.size() == 0) begin
        errors++;
        $display("%0t: unexpected duty item, expected none, got %h", $time, m_tdata);
      end else begin
        want = pending_duty.pop_front();
        duties_checked++;
        for (int ch = 0; ch < CH_COUNT; ch++) begin
          if (m_tdata[8*ch +: 8] !== want[8*ch +: 8]) begin
            errors++;
            $display("%0t: %s duty expected %0d, got %0d", $time, chan_name[ch],
                     want[8*ch +: 8], m_tdata[8*ch +: 8]);
          end
        end
      end
    end
  end

  initial begin : run_limit
    #10_000_000;
    $display("rgb_color_fade_ramp_core_tb failed");
    $finish;
  end

  initial begin : main_seq
    for (int ch = 0; ch < CH_COUNT; ch++) begin
      fade_start[ch] = '0;
      fade_goal[ch]  = '0;
    end
    fade_pct     = PCT_FULL;
    fade_elapsed = '0;
    fade_len     = DUR_RESET;
    fade_bright  = BRIGHT_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_zero_duration();
    test_bright_extremes();
    test_output_stall();
    test_random_ramps();
    drain();

    $display("run: %0d items sent, %0d acted on, %0d duty results checked",
             items_sent, live_items, duties_checked);
    $display("run: %0d register writes, durations 0 to 65535, brightness 0 to 127",
             reg_writes);
    if (errors == 0) begin
      $display("rgb_color_fade_ramp_core_tb passed");
    end else begin
      $display("rgb_color_fade_ramp_core_tb failed");
    end
    $finish;
  end

endmodule
